// ----- rtl/vun_pkg.sv -----
// ---------------------------------------------------------------------------
// vun_pkg
// Widths, constants and cell data types of the vector unit normaliser.
// ---------------------------------------------------------------------------
package vun_pkg;

   // component width; all other widths follow from it
   localparam int CompW      = 16;
   localparam int Lanes      = 4;
   localparam int MagW       = CompW;
   localparam int SqW        = 2 * CompW;
   localparam int SumW       = 2 * CompW + 1;
   localparam int RootW      = CompW + 1;
   localparam int SqrtSteps  = CompW + 1;
   localparam int SqrtStepW  = $clog2(SqrtSteps);
   localparam int NumW       = 2 * CompW - 1;
   localparam int QuoW       = CompW;
   localparam int DivSteps   = CompW;
   localparam int DivStepW   = $clog2(DivSteps);

   localparam logic [QuoW-1:0] MaxPos = {1'b0, {(QuoW-1){1'b1}}};

   // data carried through the square-root cells
   typedef struct packed {
      logic [Lanes-1:0]           neg;
      logic [Lanes-1:0][MagW-1:0] mag;
      logic                       zero;
      logic [SumW:0]              rem;
      logic [SumW:0]              res;
   } sq_data_type;

   // data carried through the divider cells
   typedef struct packed {
      logic [Lanes-1:0]           neg;
      logic                       zero;
      logic [RootW-1:0]           root;
      logic [Lanes-1:0][NumW-1:0] rem;
      logic [Lanes-1:0][QuoW-1:0] quo;
   } dv_data_type;

endpackage

// ----- rtl/vector_unit_normalizer_core.sv -----
// ---------------------------------------------------------------------------
// vector_unit_normalizer_core
// Normalises a 3- or 4-element signed vector to unit length in Q1.15.
// ---------------------------------------------------------------------------
//  channel | ports                           | direction
//  --------+---------------------------------+----------
//  request | req_valid/ready, mode, comp_*   | in
//  result  | rsp_valid/ready, unit_*, zero   | out
//
// One request per cycle sustained while the result side accepts; 3 front stages,
// 17 square-root cells, 16 divider cells and an output register.
// Each stage holds its own valid bit, so bubbles close up under a stall and
// requests are taken while a result waits, until every stage is full.
// Reset is synchronous and clears only valid bits.
// ---------------------------------------------------------------------------
module vector_unit_normalizer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic signed [vun_pkg::CompW-1:0] req_comp_x,
   input  logic signed [vun_pkg::CompW-1:0] req_comp_y,
   input  logic signed [vun_pkg::CompW-1:0] req_comp_z,
   input  logic signed [vun_pkg::CompW-1:0] req_comp_w,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [vun_pkg::CompW-1:0] rsp_unit_x,
   output logic signed [vun_pkg::CompW-1:0] rsp_unit_y,
   output logic signed [vun_pkg::CompW-1:0] rsp_unit_z,
   output logic signed [vun_pkg::CompW-1:0] rsp_unit_w,
   output logic                            rsp_zero_vector
);
   import vun_pkg::*;

   logic [Lanes-1:0][CompW-1:0] raw;
   logic [Lanes-1:0]            use_lane;

   // stage a: sign and magnitude
   logic                        a_valid_ff, a_ready;
   logic [Lanes-1:0]            a_neg_ff;
   logic [Lanes-1:0][MagW-1:0]  a_mag_ff;
   logic [Lanes-1:0]            a_neg_in;
   logic [Lanes-1:0][MagW-1:0]  a_mag_in;
   // stage b: squares
   logic                        b_valid_ff, b_ready;
   logic [Lanes-1:0]            b_neg_ff;
   logic [Lanes-1:0][MagW-1:0]  b_mag_ff;
   logic [Lanes-1:0][SqW-1:0]   b_sq_ff;
   // stage c: sum of squares
   logic                        c_ready;
   logic                        sq_valid [SqrtSteps+1];
   logic                        sq_ready [SqrtSteps+1];
   sq_data_type                 sq_data  [SqrtSteps+1];
   logic [SumW-1:0]             sum_in;
   sq_data_type                 c_data_in;
   // divider chain
   logic                        dv_valid [DivSteps+1];
   logic                        dv_ready [DivSteps+1];
   dv_data_type                 dv_data  [DivSteps+1];
   // output register
   logic                        o_valid_ff, o_ready;
   logic [Lanes-1:0][CompW-1:0] o_unit_ff, o_unit_in;
   logic                        o_zero_ff;

   assign raw      = {req_comp_w, req_comp_z, req_comp_y, req_comp_x};
   assign use_lane = {req_mode, 3'b111};

   // front: magnitudes, fourth lane cleared in three-element mode
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         a_neg_in[l] = raw[l][CompW-1] && use_lane[l];
         if (!use_lane[l]) begin
            a_mag_in[l] = '0;
         end else if (raw[l][CompW-1]) begin
            a_mag_in[l] = MagW'(-raw[l]);
         end else begin
            a_mag_in[l] = MagW'(raw[l]);
         end
      end
   end

   assign a_ready   = !a_valid_ff || b_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign req_ready = a_ready;

   // sum of squares
   always_comb begin
      sum_in = '0;
      for (int l = 0; l < Lanes; l++) begin
         sum_in = sum_in + SumW'(b_sq_ff[l]);
      end
      c_data_in.neg  = b_neg_ff;
      c_data_in.mag  = b_mag_ff;
      c_data_in.zero = (sum_in == '0);
      c_data_in.rem  = (SumW+1)'(sum_in);
      c_data_in.res  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         sq_valid[0] <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) sq_valid[0] <= b_valid_ff;
      end
      if (a_ready && req_valid) begin
         a_neg_ff <= a_neg_in;
         a_mag_ff <= a_mag_in;
      end
      if (b_ready && a_valid_ff) begin
         b_neg_ff <= a_neg_ff;
         b_mag_ff <= a_mag_ff;
         for (int l = 0; l < Lanes; l++) begin
            b_sq_ff[l] <= a_mag_ff[l] * a_mag_ff[l];
         end
      end
      if (c_ready && b_valid_ff) begin
         sq_data[0] <= c_data_in;
      end
   end

   assign c_ready = !sq_valid[0] || sq_ready[0];

   // square-root chain, most significant digit first
   for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
      vun_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_step (SqrtStepW'(SqrtSteps - 1 - i)),
         .in_valid  (sq_valid[i]),
         .in_ready  (sq_ready[i]),
         .in_data   (sq_data[i]),
         .out_valid (sq_valid[i+1]),
         .out_ready (sq_ready[i+1]),
         .out_data  (sq_data[i+1])
      );
   end

   // hand over to the divider: numerator is mag scaled by 2^(CompW-1)
   assign dv_valid[0]        = sq_valid[SqrtSteps];
   assign sq_ready[SqrtSteps] = dv_ready[0];
   always_comb begin
      dv_data[0].neg  = sq_data[SqrtSteps].neg;
      dv_data[0].zero = sq_data[SqrtSteps].zero;
      dv_data[0].root = sq_data[SqrtSteps].res[RootW-1:0];
      dv_data[0].quo  = '0;
      for (int l = 0; l < Lanes; l++) begin
         dv_data[0].rem[l] = NumW'(sq_data[SqrtSteps].mag[l]) << (CompW - 1);
      end
   end

   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      vun_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_step (DivStepW'(DivSteps - 1 - i)),
         .in_valid  (dv_valid[i]),
         .in_ready  (dv_ready[i]),
         .in_data   (dv_data[i]),
         .out_valid (dv_valid[i+1]),
         .out_ready (dv_ready[i+1]),
         .out_data  (dv_data[i+1])
      );
   end

   // sign restore and saturation
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         if (dv_data[DivSteps].zero) begin
            o_unit_in[l] = '0;
         end else if (dv_data[DivSteps].neg[l]) begin
            o_unit_in[l] = CompW'(-dv_data[DivSteps].quo[l]);
         end else if (dv_data[DivSteps].quo[l] > MaxPos) begin
            o_unit_in[l] = CompW'(MaxPos);
         end else begin
            o_unit_in[l] = CompW'(dv_data[DivSteps].quo[l]);
         end
      end
   end

   assign o_ready            = !o_valid_ff || rsp_ready;
   assign dv_ready[DivSteps] = o_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= dv_valid[DivSteps];
      end
      if (o_ready && dv_valid[DivSteps]) begin
         o_unit_ff <= o_unit_in;
         o_zero_ff <= dv_data[DivSteps].zero;
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_unit_x      = o_unit_ff[0];
   assign rsp_unit_y      = o_unit_ff[1];
   assign rsp_unit_z      = o_unit_ff[2];
   assign rsp_unit_w      = o_unit_ff[3];
   assign rsp_zero_vector = o_zero_ff;

   // a zero vector gives all-zero components
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |->
         rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0 && rsp_unit_w == '0)
      else $error("zero vector with non-zero component");

   // the pipe only refuses requests when the result side is backed up
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused while output free");

   // nothing is offered in the first cycle after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ----- rtl/vun_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// vun_sqrt_cell
// One digit of the integer square root, registered, with handshake.
// ---------------------------------------------------------------------------
module vun_sqrt_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [vun_pkg::SqrtStepW-1:0]  cell_step,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  vun_pkg::sq_data_type           in_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output vun_pkg::sq_data_type           out_data
);
   import vun_pkg::*;

   logic        valid_ff;
   sq_data_type data_ff;
   sq_data_type data_in;
   logic [SumW:0] bit_val;
   logic [SumW:0] trial;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // trial subtract of res + 4^step
   always_comb begin
      bit_val = (SumW+1)'(1) << {cell_step, 1'b0};
      trial   = in_data.res + bit_val;
      data_in = in_data;
      if (in_data.rem >= trial) begin
         data_in.rem = in_data.rem - trial;
         data_in.res = (in_data.res >> 1) + bit_val;
      end else begin
         data_in.res = in_data.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/vun_div_cell.sv -----
// ---------------------------------------------------------------------------
// vun_div_cell
// One quotient bit of four parallel restoring divisions, registered.
// ---------------------------------------------------------------------------
module vun_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [vun_pkg::DivStepW-1:0]  cell_step,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  vun_pkg::dv_data_type          in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output vun_pkg::dv_data_type          out_data
);
   import vun_pkg::*;

   logic        valid_ff;
   dv_data_type data_ff;
   dv_data_type data_in;
   logic [NumW:0] divisor;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // compare each lane against root shifted to this bit
   always_comb begin
      divisor = (NumW+1)'(in_data.root) << cell_step;
      data_in = in_data;
      for (int l = 0; l < Lanes; l++) begin
         if ({1'b0, in_data.rem[l]} >= divisor) begin
            data_in.rem[l] = NumW'({1'b0, in_data.rem[l]} - divisor);
            data_in.quo[l] = in_data.quo[l] | (QuoW'(1) << cell_step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
